// File: hdl/bf16hp_pkg.sv
// Shared types and constants for the bfloat16 exponent Huffman packer.
`timescale 1ns / 1ps

package bf16hp_pkg;

  // Default parameter values
  localparam int unsigned POS_BLOCK_BITS_DEF = 32768;
  localparam int unsigned MAX_CODE_BITS_DEF  = 32;

  // Stream port widths
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LEN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_WORD = 1'b1;

  // Field and counter widths
  localparam int unsigned VALUE_W   = 37;
  localparam int unsigned STREAM_W  = 40;
  localparam int unsigned CHUNK_SH  = 6;
  localparam int unsigned CHUNKS_W  = 34;
  localparam int unsigned BLOCKS_W  = 25;
  localparam int unsigned SCOUNT_W  = 32;
  localparam int unsigned BYTES_W   = 37;
  localparam int unsigned TBL_DEPTH = 256;

  // Command codes (slave tuser)
  localparam logic [S_TUSER_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [S_TUSER_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [S_TUSER_W-1:0] CMD_FINISH = 2'd2;

  // Result kinds (master tuser)
  localparam logic [M_TUSER_W-1:0] KIND_SM     = 3'd0;
  localparam logic [M_TUSER_W-1:0] KIND_BYTE   = 3'd1;
  localparam logic [M_TUSER_W-1:0] KIND_GAP    = 3'd2;
  localparam logic [M_TUSER_W-1:0] KIND_POS    = 3'd3;
  localparam logic [M_TUSER_W-1:0] KIND_BCOUNT = 3'd4;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_GAP,
    S_POS,
    S_SM,
    S_BYTE,
    S_FINAL,
    S_SCNT,
    S_BCNT
  } state_e;

endpackage

// File: hdl/bf16_exponent_huffman_packer.sv
// Top level: bfloat16 exponent Huffman encoder with byte-serial bit packer.
`timescale 1ns / 1ps

// Commands arrive on the slave stream (tuser = command). A table load gives no
// word. An encode reads the code table when it is accepted, aligns the code
// behind the pending residue bits in a shift register, then emits its result
// words: optional gap offset, optional sample position, the sign-mantissa byte
// and zero to four encoded bytes, shifted out a byte per cycle. A finish aligns
// the end code, emits optional gap/position, a final byte (only when residue
// bits are pending), sample count and byte count, and clears the stream state.
// The single output register sets the pace: one result word per cycle, and the
// sequencer waits while that register is held by the sink. A code table entry
// must be loaded before any encode uses it.
module bf16_exponent_huffman_packer #(
  parameter int unsigned POSITION_BLOCK_BITS = bf16hp_pkg::POS_BLOCK_BITS_DEF,
  parameter int unsigned MAX_CODE_BITS       = bf16hp_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [bf16hp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bf16hp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Slave stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: sample[15:0], table_symbol[23:16], entry_length[29:24],
  //        entry_code[61:30], zero[63:62]
  input  logic [bf16hp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [bf16hp_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  // Master stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: value[36:0], zero[39:37]
  output logic [bf16hp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // tuser: kind[2:0]
  output logic [bf16hp_pkg::M_TUSER_W-1:0]  m_axis_tuser,
  output logic                              m_axis_tlast
);

  import bf16hp_pkg::*;

  localparam int unsigned CW   = MAX_CODE_BITS;
  localparam int unsigned LW   = $clog2(CW + 1);
  localparam int unsigned SRW  = CW + 8;
  localparam int unsigned PW   = $clog2(SRW + 1);
  localparam int unsigned TW   = BLOCKS_W + $clog2(POSITION_BLOCK_BITS + 1);
  localparam int unsigned CMPW = (TW > STREAM_W) ? TW : STREAM_W;
  localparam int unsigned AW   = $clog2(TBL_DEPTH);

  // Sequencer and stream state
  state_e                  state_q, state_d;
  logic                    fin_q;
  logic [PW-1:0]           pend_q;
  logic [6:0]              res_q;
  logic [2:0]              rc_q;
  logic [STREAM_W-1:0]     stream_q;
  logic [SCOUNT_W-1:0]     scount_q;
  logic [CHUNKS_W-1:0]     chunks_q;
  logic [BLOCKS_W-1:0]     blocks_q;
  logic [TW-1:0]           thr_q;
  logic [BYTES_W-1:0]      bytes_q;
  logic                    blk_due_q;
  logic [5:0]              end_len_q;
  logic [CFG_DATA_W-1:0]   end_word_q;

  // Payload registers
  logic [7:0]              smb_q;
  logic [5:0]              gap_val_q;
  logic [SRW-1:0]          sr_q;
  logic [LW-1:0]           rd_len_q;
  logic [CW-1:0]           rd_code_q;

  // Output register
  logic                    m_valid_q;
  logic [M_TUSER_W-1:0]    m_kind_q;
  logic [VALUE_W-1:0]      m_value_q;
  logic                    m_last_q;

  // Code table
  logic [LW+CW-1:0]        tbl_mem [TBL_DEPTH];

  logic                    s_acc;
  logic                    out_free;
  logic                    emit_en;
  logic [M_TUSER_W-1:0]    emit_kind;
  logic [VALUE_W-1:0]      emit_value;
  logic                    emit_last;
  logic [LW-1:0]           ld_len;
  logic [LW-1:0]           end_len_c;
  logic [LW-1:0]           src_len;
  logic [CW-1:0]           src_code;
  logic [CW-1:0]           code_al;
  logic [SRW-1:0]          sr_new;
  logic [PW-1:0]           pend_new;
  logic                    mark_ok;
  logic                    gap_due;
  logic                    blk_due;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Length clamps
  assign ld_len    = (s_axis_tdata[29:24] > 6'(CW)) ? LW'(CW) : LW'(s_axis_tdata[29:24]);
  assign end_len_c = (end_len_q > 6'(CW)) ? LW'(CW) : LW'(end_len_q);

  // Code alignment: left-justify the code, then place it behind the residue
  assign src_len  = fin_q ? end_len_c : rd_len_q;
  assign src_code = fin_q ? end_word_q[CW-1:0] : rd_code_q;
  assign code_al  = src_code << (LW'(CW) - src_len);
  assign sr_new   = {res_q, {(SRW-7){1'b0}}} | ({code_al, 8'h00} >> rc_q);
  assign pend_new = PW'(rc_q) + PW'(src_len);

  // Chunk and block marker checks on the stream length before this code
  assign mark_ok = !fin_q || (rc_q != 3'd0);
  assign gap_due = mark_ok && (stream_q[STREAM_W-1:CHUNK_SH] >= chunks_q);
  assign blk_due = mark_ok && (CMPW'(stream_q) >= CMPW'(thr_q));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc && (s_axis_tuser == CMD_ENCODE || s_axis_tuser == CMD_FINISH)) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        priority if (fin_q && rc_q == 3'd0) begin
          state_d = S_SCNT;
        end else if (gap_due) begin
          state_d = S_GAP;
        end else if (blk_due) begin
          state_d = S_POS;
        end else begin
          state_d = fin_q ? S_FINAL : S_SM;
        end
      end
      S_GAP: begin
        if (out_free) begin
          state_d = blk_due_q ? S_POS : (fin_q ? S_FINAL : S_SM);
        end
      end
      S_POS: begin
        if (out_free) begin
          state_d = fin_q ? S_FINAL : S_SM;
        end
      end
      S_SM: begin
        if (out_free) begin
          state_d = (pend_q < PW'(8)) ? S_IDLE : S_BYTE;
        end
      end
      S_BYTE: begin
        if (out_free) begin
          state_d = (pend_q < PW'(16)) ? S_IDLE : S_BYTE;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          state_d = S_SCNT;
        end
      end
      S_SCNT: begin
        if (out_free) begin
          state_d = S_BCNT;
        end
      end
      S_BCNT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: ready and the word to load
  always_comb begin
    s_axis_tready = 1'b0;
    emit_en       = 1'b0;
    emit_kind     = KIND_SM;
    emit_value    = '0;
    emit_last     = 1'b0;
    unique case (state_q)
      S_IDLE: s_axis_tready = 1'b1;
      S_LOOK: ;
      S_GAP: begin
        emit_en    = out_free;
        emit_kind  = KIND_GAP;
        emit_value = VALUE_W'(gap_val_q);
      end
      S_POS: begin
        emit_en    = out_free;
        emit_kind  = KIND_POS;
        emit_value = VALUE_W'(scount_q);
      end
      S_SM: begin
        emit_en    = out_free;
        emit_kind  = KIND_SM;
        emit_value = VALUE_W'(smb_q);
        emit_last  = pend_q < PW'(8);
      end
      S_BYTE: begin
        emit_en    = out_free;
        emit_kind  = KIND_BYTE;
        emit_value = VALUE_W'(sr_q[SRW-1 -: 8]);
        emit_last  = pend_q < PW'(16);
      end
      S_FINAL: begin
        emit_en    = out_free;
        emit_kind  = KIND_BYTE;
        emit_value = VALUE_W'(sr_q[SRW-1 -: 8]);
      end
      S_SCNT: begin
        emit_en    = out_free;
        emit_kind  = KIND_POS;
        emit_value = VALUE_W'(scount_q);
      end
      S_BCNT: begin
        emit_en    = out_free;
        emit_kind  = KIND_BCOUNT;
        emit_value = VALUE_W'(bytes_q);
        emit_last  = 1'b1;
      end
      default: ;
    endcase
  end

  // Control state, counters and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fin_q      <= 1'b0;
      pend_q     <= '0;
      res_q      <= '0;
      rc_q       <= '0;
      stream_q   <= '0;
      scount_q   <= '0;
      chunks_q   <= '0;
      blocks_q   <= '0;
      thr_q      <= '0;
      bytes_q    <= '0;
      blk_due_q  <= 1'b0;
      end_len_q  <= '0;
      end_word_q <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_END_LEN:  end_len_q  <= cfg_wdata_i[5:0];
          CFG_END_WORD: end_word_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (s_acc) begin
        fin_q <= (s_axis_tuser == CMD_FINISH);
      end

      // Alignment step
      if (state_q == S_LOOK) begin
        pend_q    <= pend_new;
        blk_due_q <= blk_due;
        if (!fin_q) begin
          stream_q <= stream_q + STREAM_W'(src_len);
        end
      end

      if (emit_en) begin
        unique case (state_q)
          S_GAP: chunks_q <= chunks_q + 1'b1;
          S_POS: begin
            blocks_q <= blocks_q + 1'b1;
            thr_q    <= (blocks_q == '1) ? '0 : thr_q + TW'(POSITION_BLOCK_BITS);
          end
          S_SM: begin
            scount_q <= scount_q + 1'b1;
            if (pend_q < PW'(8)) begin
              res_q <= sr_q[SRW-1 -: 7];
              rc_q  <= pend_q[2:0];
            end
          end
          S_BYTE: begin
            pend_q  <= pend_q - PW'(8);
            bytes_q <= bytes_q + 1'b1;
            if (pend_q < PW'(16)) begin
              res_q <= sr_q[SRW-9 -: 7];
              rc_q  <= pend_q[2:0];
            end
          end
          S_FINAL: bytes_q <= bytes_q + 1'b1;
          S_BCNT: begin
            res_q    <= '0;
            rc_q     <= '0;
            stream_q <= '0;
            scount_q <= '0;
            chunks_q <= '0;
            blocks_q <= '0;
            thr_q    <= '0;
            bytes_q  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Payload: sample byte, gap offset, bit shift register
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      smb_q <= {s_axis_tdata[15], s_axis_tdata[6:0]};
    end
    if (state_q == S_LOOK) begin
      sr_q      <= sr_new;
      gap_val_q <= stream_q[CHUNK_SH-1:0];
    end else if (emit_en && state_q == S_BYTE) begin
      sr_q <= sr_q << 8;
    end
  end

  // Code table: written on load, read on encode
  always_ff @(posedge clk_i) begin
    if (s_acc && s_axis_tuser == CMD_LOAD) begin
      tbl_mem[s_axis_tdata[16 +: AW]] <= {ld_len, s_axis_tdata[30 +: CW]};
    end
    if (s_acc && s_axis_tuser == CMD_ENCODE) begin
      {rd_len_q, rd_code_q} <= tbl_mem[s_axis_tdata[7 +: AW]];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit_en) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      m_kind_q  <= emit_kind;
      m_value_q <= emit_value;
      m_last_q  <= emit_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(m_value_q);
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

`ifndef NO_ASSERTIONS
  // An accepted encode always goes to the table read / alignment step
  a_enc_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tuser == CMD_ENCODE) |=> (state_q == S_LOOK))
    else $error("encode not followed by alignment step");

  // Byte emission only with at least a full byte pending
  a_byte_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BYTE) |-> (pend_q >= PW'(8)))
    else $error("byte state with fewer than eight pending bits");

  // Byte count word closes the finish and carries the last flag
  a_bcnt_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_en && state_q == S_BCNT) |=>
      (m_axis_tvalid && m_axis_tlast && m_axis_tuser == KIND_BCOUNT))
    else $error("byte count word malformed");

  // Stream state is cleared after a finish
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_en && state_q == S_BCNT) |=>
      (stream_q == '0 && rc_q == 3'd0 && bytes_q == '0 && scount_q == '0))
    else $error("stream state not cleared after finish");
`endif

endmodule
